[sv/segi_pkg.sv]
// Package for the segment intersection block: widths, status codes and item types.
package segi_pkg;

   // Coordinate width and the exact widths that follow from it.
   localparam int CW  = 16;          // coordinate
   localparam int AW  = CW + 1;      // line coefficients a and b
   localparam int PW  = 2 * CW;      // coordinate by coordinate product
   localparam int CCW = 2 * CW + 1;  // line coefficient c
   localparam int XW  = 2 * CW + 1;  // coefficient by coordinate product
   localparam int SW  = 2 * CW + 3;  // side value of an endpoint
   localparam int EW  = 2 * CW + 2;  // coefficient by coefficient product
   localparam int DW  = 2 * CW + 3;  // determinant
   localparam int TW  = 3 * CW + 2;  // numerator partial product
   localparam int NW  = 3 * CW + 3;  // numerator
   localparam int MW  = NW + 1;      // rounded numerator magnitude
   localparam int QW  = CW + 1;      // quotient bits worked out by the divider cells

   typedef enum logic [1:0] {
      ST_NONE      = 2'd0,
      ST_HIT       = 2'd1,
      ST_COLLINEAR = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [CW-1:0] ax0;
      logic signed [CW-1:0] ay0;
      logic signed [CW-1:0] ax1;
      logic signed [CW-1:0] ay1;
      logic signed [CW-1:0] bx0;
      logic signed [CW-1:0] by0;
      logic signed [CW-1:0] bx1;
      logic signed [CW-1:0] by1;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic signed [CW-1:0] hit_x;
      logic signed [CW-1:0] hit_y;
   } rsp_type;

   // Work carried from cell to cell along the divider chain.
   typedef struct packed {
      logic [DW-1:0] rem_x;
      logic [DW-1:0] rem_y;
      logic [QW-1:0] low_x;
      logic [QW-1:0] low_y;
      logic [QW-1:0] q_x;
      logic [QW-1:0] q_y;
      logic [DW-1:0] dm;
      logic          neg_x;
      logic          neg_y;
      status_type    status;
   } div_type;

endpackage

[sv/segi_front.sv]
// Five-stage front end: line equations, side tests, determinant and numerators.
module segi_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  segi_pkg::req_type in_data,
   output logic              in_ready,
   output logic              out_valid,
   output segi_pkg::div_type out_data,
   input  logic              out_ready
);

   localparam int CW  = segi_pkg::CW;
   localparam int AW  = segi_pkg::AW;
   localparam int PW  = segi_pkg::PW;
   localparam int CCW = segi_pkg::CCW;
   localparam int XW  = segi_pkg::XW;
   localparam int SW  = segi_pkg::SW;
   localparam int EW  = segi_pkg::EW;
   localparam int DW  = segi_pkg::DW;
   localparam int TW  = segi_pkg::TW;
   localparam int NW  = segi_pkg::NW;
   localparam int MW  = segi_pkg::MW;
   localparam int QW  = segi_pkg::QW;

   logic [5:1] v_ff, v_in;
   logic [6:1] rdy;

   always_comb begin
      rdy[6] = out_ready;
      for (int k = 5; k >= 1; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
      v_in[1] = rdy[1] ? in_valid : v_ff[1];
      for (int k = 2; k <= 5; k++) begin
         v_in[k] = rdy[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign in_ready  = rdy[1];
   assign out_valid = v_ff[5];

   // Stage 1: coefficients a, b and the cross products that make c.
   logic signed [CW-1:0] x1_ff, y1_ff, x2_ff, y2_ff, x3_ff, y3_ff, x4_ff, y4_ff;
   logic signed [AW-1:0] a1_ff, b1_ff, a2_ff, b2_ff;
   logic signed [PW-1:0] p11_ff, p12_ff, p21_ff, p22_ff;

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         x1_ff  <= in_data.ax0;
         y1_ff  <= in_data.ay0;
         x2_ff  <= in_data.ax1;
         y2_ff  <= in_data.ay1;
         x3_ff  <= in_data.bx0;
         y3_ff  <= in_data.by0;
         x4_ff  <= in_data.bx1;
         y4_ff  <= in_data.by1;
         a1_ff  <= AW'(in_data.ay1) - AW'(in_data.ay0);
         b1_ff  <= AW'(in_data.ax0) - AW'(in_data.ax1);
         a2_ff  <= AW'(in_data.by1) - AW'(in_data.by0);
         b2_ff  <= AW'(in_data.bx0) - AW'(in_data.bx1);
         p11_ff <= PW'(in_data.ax1) * PW'(in_data.ay0);
         p12_ff <= PW'(in_data.ax0) * PW'(in_data.ay1);
         p21_ff <= PW'(in_data.bx1) * PW'(in_data.by0);
         p22_ff <= PW'(in_data.bx0) * PW'(in_data.by1);
      end
   end

   // Stage 2: coefficient c of each line.
   logic signed [CW-1:0]  x1b_ff, y1b_ff, x2b_ff, y2b_ff, x3b_ff, y3b_ff, x4b_ff, y4b_ff;
   logic signed [AW-1:0]  a1b_ff, b1b_ff, a2b_ff, b2b_ff;
   logic signed [CCW-1:0] c1_ff, c2_ff;

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         x1b_ff <= x1_ff;
         y1b_ff <= y1_ff;
         x2b_ff <= x2_ff;
         y2b_ff <= y2_ff;
         x3b_ff <= x3_ff;
         y3b_ff <= y3_ff;
         x4b_ff <= x4_ff;
         y4b_ff <= y4_ff;
         a1b_ff <= a1_ff;
         b1b_ff <= b1_ff;
         a2b_ff <= a2_ff;
         b2b_ff <= b2_ff;
         c1_ff  <= CCW'(p11_ff) - CCW'(p12_ff);
         c2_ff  <= CCW'(p21_ff) - CCW'(p22_ff);
      end
   end

   // Stage 3: every product of the side values, determinant and numerators.
   logic signed [XW-1:0]  sa3_ff, sb3_ff, sa4_ff, sb4_ff;
   logic signed [XW-1:0]  ta1_ff, tb1_ff, ta2_ff, tb2_ff;
   logic signed [EW-1:0]  d1_ff, d2_ff;
   logic signed [TW-1:0]  n1_ff, n2_ff, n3_ff, n4_ff;
   logic signed [CCW-1:0] c1c_ff, c2c_ff;

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         sa3_ff <= XW'(a1b_ff) * XW'(x3b_ff);
         sb3_ff <= XW'(b1b_ff) * XW'(y3b_ff);
         sa4_ff <= XW'(a1b_ff) * XW'(x4b_ff);
         sb4_ff <= XW'(b1b_ff) * XW'(y4b_ff);
         ta1_ff <= XW'(a2b_ff) * XW'(x1b_ff);
         tb1_ff <= XW'(b2b_ff) * XW'(y1b_ff);
         ta2_ff <= XW'(a2b_ff) * XW'(x2b_ff);
         tb2_ff <= XW'(b2b_ff) * XW'(y2b_ff);
         d1_ff  <= EW'(a1b_ff) * EW'(b2b_ff);
         d2_ff  <= EW'(a2b_ff) * EW'(b1b_ff);
         n1_ff  <= TW'(b1b_ff) * TW'(c2_ff);
         n2_ff  <= TW'(b2b_ff) * TW'(c1_ff);
         n3_ff  <= TW'(a2b_ff) * TW'(c1_ff);
         n4_ff  <= TW'(a1b_ff) * TW'(c2_ff);
         c1c_ff <= c1_ff;
         c2c_ff <= c2_ff;
      end
   end

   // Stage 4: side values, determinant and numerators.
   logic signed [SW-1:0] s3_ff, s4_ff, s1_ff, s2_ff;
   logic signed [DW-1:0] den_ff;
   logic signed [NW-1:0] xnum_ff, ynum_ff;

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         s3_ff   <= SW'(sa3_ff) + SW'(sb3_ff) + SW'(c1c_ff);
         s4_ff   <= SW'(sa4_ff) + SW'(sb4_ff) + SW'(c1c_ff);
         s1_ff   <= SW'(ta1_ff) + SW'(tb1_ff) + SW'(c2c_ff);
         s2_ff   <= SW'(ta2_ff) + SW'(tb2_ff) + SW'(c2c_ff);
         den_ff  <= DW'(d1_ff) - DW'(d2_ff);
         xnum_ff <= NW'(n1_ff) - NW'(n2_ff);
         ynum_ff <= NW'(n3_ff) - NW'(n4_ff);
      end
   end

   // Stage 5: status, magnitudes with the rounding offset, divider start.
   function automatic logic same_side(logic signed [SW-1:0] r, logic signed [SW-1:0] s);
      same_side = (r != '0) && (s != '0) && (r[SW-1] == s[SW-1]);
   endfunction

   segi_pkg::status_type status;
   logic [DW-1:0]        dm, off;
   logic [MW-1:0]        mx, my;
   segi_pkg::div_type    div_in;

   always_comb begin
      priority if (same_side(s3_ff, s4_ff) || same_side(s1_ff, s2_ff)) begin
         status = segi_pkg::ST_NONE;
      end else if (den_ff == '0) begin
         status = segi_pkg::ST_COLLINEAR;
      end else begin
         status = segi_pkg::ST_HIT;
      end
      dm  = den_ff[DW-1] ? DW'(-den_ff) : DW'(den_ff);
      off = dm >> 1;
      mx  = (xnum_ff[NW-1] ? MW'(-NW'(xnum_ff)) : MW'(NW'(xnum_ff))) + MW'(off);
      my  = (ynum_ff[NW-1] ? MW'(-NW'(ynum_ff)) : MW'(NW'(ynum_ff))) + MW'(off);
      // Where the pair meets, the quotient fits the cells, so the bits above
      // them are already smaller than the divisor and form the start remainder.
      div_in.rem_x  = DW'(mx >> QW);
      div_in.rem_y  = DW'(my >> QW);
      div_in.low_x  = mx[QW-1:0];
      div_in.low_y  = my[QW-1:0];
      div_in.q_x    = '0;
      div_in.q_y    = '0;
      div_in.dm     = dm;
      div_in.neg_x  = xnum_ff[NW-1] ^ den_ff[DW-1];
      div_in.neg_y  = ynum_ff[NW-1] ^ den_ff[DW-1];
      div_in.status = status;
   end

   always_ff @(posedge clock) begin
      if (rdy[5]) begin
         out_data <= div_in;
      end
   end

endmodule

[sv/segi_div_cell.sv]
// One restoring division cell: one quotient bit for both coordinates.
module segi_div_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  segi_pkg::div_type in_data,
   output logic              in_ready,
   output logic              out_valid,
   output segi_pkg::div_type out_data,
   input  logic              out_ready
);

   localparam int DW = segi_pkg::DW;
   localparam int QW = segi_pkg::QW;

   logic              valid_ff;
   logic [DW:0]       tx, ty, nx, ny;
   logic              gx, gy;
   segi_pkg::div_type nxt;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;

   always_comb begin
      tx  = {in_data.rem_x, in_data.low_x[QW-1]};
      ty  = {in_data.rem_y, in_data.low_y[QW-1]};
      gx  = tx >= {1'b0, in_data.dm};
      gy  = ty >= {1'b0, in_data.dm};
      nx  = gx ? tx - {1'b0, in_data.dm} : tx;
      ny  = gy ? ty - {1'b0, in_data.dm} : ty;
      nxt = in_data;
      nxt.rem_x = nx[DW-1:0];
      nxt.rem_y = ny[DW-1:0];
      nxt.low_x = {in_data.low_x[QW-2:0], 1'b0};
      nxt.low_y = {in_data.low_y[QW-2:0], 1'b0};
      nxt.q_x   = {in_data.q_x[QW-2:0], gx};
      nxt.q_y   = {in_data.q_y[QW-2:0], gy};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         out_data <= nxt;
      end
   end

endmodule

[sv/segi_top_note.sv]
// Output stage: sign, width and status masking of the divided coordinates.
module segi_out (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  segi_pkg::div_type in_data,
   output logic              in_ready,
   output logic              rsp_valid,
   output segi_pkg::rsp_type rsp_data,
   input  logic              rsp_stall
);

   localparam int CW = segi_pkg::CW;
   localparam int QW = segi_pkg::QW;

   logic              valid_ff;
   logic [QW-1:0]     qx, qy;
   segi_pkg::rsp_type nxt;

   assign in_ready  = !valid_ff || !rsp_stall;
   assign rsp_valid = valid_ff;

   always_comb begin
      qx = in_data.neg_x ? -in_data.q_x : in_data.q_x;
      qy = in_data.neg_y ? -in_data.q_y : in_data.q_y;
      nxt.status = in_data.status;
      if (in_data.status == segi_pkg::ST_HIT) begin
         nxt.hit_x = qx[CW-1:0];
         nxt.hit_y = qy[CW-1:0];
      end else begin
         nxt.hit_x = '0;
         nxt.hit_y = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         rsp_data <= nxt;
      end
   end

endmodule

[sv/segment_intersection.sv]
// Top level of the segment intersection block: front end, divider chain, output stage.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_stall  segi_pkg::req_type (two segments)
//   rsp      out        rsp_valid / rsp_stall  segi_pkg::rsp_type (status, point)
//
// One item is accepted and one result leaves in every cycle while rsp is not stalled.
// The pipeline is five front-end stages, then a chain of QW division cells,
// one quotient bit each, then the output register.
// Reset clears only the valid bits of the stages; the data registers are not reset.
// A stall on rsp holds the output register; any empty stage upstream still
// fills, so req_stall rises only once every stage is holding an item.
module segment_intersection (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  segi_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output segi_pkg::rsp_type rsp_data
);

   localparam int QW = segi_pkg::QW;

   // Handshake and work along the chain; index 0 is the front end's output.
   logic              cv [QW+1];
   logic              cr [QW+1];
   segi_pkg::div_type cd [QW+1];
   logic              front_ready;

   assign req_stall = !front_ready;

   // Line equations, endpoint side tests, determinant and rounded numerators.
   segi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .in_ready  (front_ready),
      .out_valid (cv[0]),
      .out_data  (cd[0]),
      .out_ready (cr[0])
   );

   // Each cell takes the next numerator bit into its remainder, subtracts
   // the divisor where it fits and shifts the quotient bit in.
   for (genvar i = 0; i < QW; i++) begin : g_cell
      segi_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cv[i]),
         .in_data   (cd[i]),
         .in_ready  (cr[i]),
         .out_valid (cv[i+1]),
         .out_data  (cd[i+1]),
         .out_ready (cr[i+1])
      );
   end

   // The quotient is given its sign and the point is zeroed unless it hits.
   segi_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cv[QW]),
      .in_data   (cd[QW]),
      .in_ready  (cr[QW]),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule
